// ===== src/keyed_request_slot_coalescer_top_defines.svh =====
// assertion macros shared by the slot coalescer checker
`ifndef KEYED_REQUEST_SLOT_COALESCER_TOP_DEFINES_SVH
`define KEYED_REQUEST_SLOT_COALESCER_TOP_DEFINES_SVH

// same-cycle implication, reset masked
`define KRSC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define KRSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/krsc_pkg.sv =====
// shared codes and control structs for the keyed request slot coalescer
`timescale 1ns / 1ps

package krsc_pkg;

  localparam int unsigned TOKEN_WIDTH = 32;

  // slot phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_QUEUED = 2'd1;
  localparam logic [1:0] PH_ACTIVE = 2'd2;

  // item type codes
  localparam logic [1:0] REQ_REQUEST  = 2'd0;
  localparam logic [1:0] REQ_ACTIVATE = 2'd1;
  localparam logic [1:0] REQ_SETTLE   = 2'd2;
  localparam logic [1:0] REQ_STORE    = 2'd3;

  // result status codes
  localparam logic [3:0] ST_QUEUED     = 4'd0;
  localparam logic [3:0] ST_WAITING    = 4'd1;
  localparam logic [3:0] ST_CACHED     = 4'd2;
  localparam logic [3:0] ST_ACTIVATED  = 4'd3;
  localparam logic [3:0] ST_REFUSED    = 4'd4;
  localparam logic [3:0] ST_IGNORED    = 4'd5;
  localparam logic [3:0] ST_SUPERSEDED = 4'd6;
  localparam logic [3:0] ST_ACCEPTED   = 4'd7;
  localparam logic [3:0] ST_STORED     = 4'd8;

  // commands from controller to datapath
  typedef struct packed {
    logic cur_load_req;     // current request from the item key
    logic cur_load_latest;  // current request from the pending latest
    logic cur_fg_merge;     // or item purpose into current purpose
    logic lat_clear;        // drop pending latest
    logic lat_load;         // new pending latest from the item
    logic lat_fg_merge;     // or item purpose into latest purpose
    logic tok_load;         // capture activation token
    logic res_store;        // overwrite retained result
    logic done_capture;     // report current request as completed
    logic item_accept;      // an item is taken this cycle
  } krsc_cmd_t;

  // compare results from datapath to controller
  typedef struct packed {
    logic cur_match;     // item key equals current request key
    logic res_match;     // retained result present with matching key
    logic lat_valid;     // a pending latest request exists
    logic lat_match;     // item key equals pending latest key
    logic tok_zero;      // item token is zero
    logic tok_match;     // item token equals active token
  } krsc_stat_t;

endpackage

// ===== src/krsc_ctrl.sv =====
// slot phase state machine and item status decode
`timescale 1ns / 1ps

module krsc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          req_type_i,
  input  logic                details_present_i,
  input  krsc_pkg::krsc_stat_t stat_i,
  output krsc_pkg::krsc_cmd_t  cmd_o,
  output logic [1:0]          phase_o,
  output logic [3:0]          status_o,
  output logic                done_o
);

  logic [1:0] phase_q, phase_d;
  logic [3:0] status_q, status_d;
  logic       done_q;
  logic       init_q;
  logic       accept;

  assign busy   = init_q;
  assign accept = start && !init_q;

  // next phase, status and datapath commands for the accepted item
  always_comb begin
    cmd_o             = '0;
    cmd_o.item_accept = accept;
    phase_d           = phase_q;
    status_d          = status_q;
    if (accept) begin
      unique case (req_type_i)
        krsc_pkg::REQ_REQUEST: begin
          if (phase_q == krsc_pkg::PH_ACTIVE) begin
            status_d = krsc_pkg::ST_WAITING;
            if (stat_i.cur_match) begin
              cmd_o.cur_fg_merge = 1'b1;
              cmd_o.lat_clear    = 1'b1;
            end else if (stat_i.res_match) begin
              cmd_o.lat_clear = 1'b1;
              status_d        = krsc_pkg::ST_CACHED;
            end else if (stat_i.lat_valid && stat_i.lat_match) begin
              cmd_o.lat_fg_merge = 1'b1;
            end else begin
              cmd_o.lat_load = 1'b1;
            end
          end else if (stat_i.res_match) begin
            status_d = krsc_pkg::ST_CACHED;
          end else begin
            cmd_o.cur_load_req = 1'b1;
            // a repeat of the queued key keeps its foreground purpose
            cmd_o.cur_fg_merge = (phase_q == krsc_pkg::PH_QUEUED) && stat_i.cur_match;
            phase_d            = krsc_pkg::PH_QUEUED;
            status_d           = krsc_pkg::ST_QUEUED;
          end
        end
        krsc_pkg::REQ_ACTIVATE: begin
          if (phase_q != krsc_pkg::PH_QUEUED || stat_i.tok_zero) begin
            status_d = krsc_pkg::ST_REFUSED;
          end else begin
            cmd_o.tok_load  = 1'b1;
            cmd_o.lat_clear = 1'b1;
            phase_d         = krsc_pkg::PH_ACTIVE;
            status_d        = krsc_pkg::ST_ACTIVATED;
          end
        end
        krsc_pkg::REQ_SETTLE: begin
          if (phase_q != krsc_pkg::PH_ACTIVE || !stat_i.tok_match) begin
            status_d = krsc_pkg::ST_IGNORED;
          end else begin
            cmd_o.done_capture = 1'b1;
            if (stat_i.lat_valid) begin
              cmd_o.cur_load_latest = 1'b1;
              cmd_o.lat_clear       = 1'b1;
              phase_d               = krsc_pkg::PH_QUEUED;
              status_d              = krsc_pkg::ST_SUPERSEDED;
            end else begin
              cmd_o.res_store = details_present_i;
              phase_d         = krsc_pkg::PH_IDLE;
              status_d        = krsc_pkg::ST_ACCEPTED;
            end
          end
        end
        krsc_pkg::REQ_STORE: begin
          cmd_o.res_store = 1'b1;
          status_d        = krsc_pkg::ST_STORED;
        end
        default: begin
          status_d = krsc_pkg::ST_IGNORED;
        end
      endcase
    end
  end

  // state, status and strobe registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= krsc_pkg::PH_IDLE;
      status_q <= krsc_pkg::ST_IGNORED;
      done_q   <= 1'b0;
      init_q   <= 1'b1;
    end else begin
      phase_q  <= phase_d;
      status_q <= status_d;
      done_q   <= accept;
      init_q   <= 1'b0;
    end
  end

  assign phase_o  = phase_q;
  assign status_o = status_q;
  assign done_o   = done_q;

endmodule

// ===== src/krsc_dpath.sv =====
// request, token and retained result registers with key compares
`timescale 1ns / 1ps

module krsc_dpath #(
  parameter int unsigned KEY_WIDTH = 32,
  parameter int unsigned TAG_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  krsc_pkg::krsc_cmd_t          cmd_i,
  output krsc_pkg::krsc_stat_t         stat_o,
  input  logic [KEY_WIDTH-1:0]         req_key_i,
  input  logic                         req_foreground_i,
  input  logic [krsc_pkg::TOKEN_WIDTH-1:0] token_i,
  input  logic [KEY_WIDTH-1:0]         details_key_i,
  input  logic [TAG_WIDTH-1:0]         details_tag_i,
  output logic [KEY_WIDTH-1:0]         current_key_o,
  output logic                         current_fg_o,
  output logic [KEY_WIDTH-1:0]         completed_key_o,
  output logic                         completed_fg_o,
  output logic                         result_valid_o,
  output logic [KEY_WIDTH-1:0]         result_key_o,
  output logic [TAG_WIDTH-1:0]         result_tag_o
);

  logic [krsc_pkg::TOKEN_WIDTH-1:0] active_token_q;
  logic [KEY_WIDTH-1:0] current_key_q, latest_key_q, result_key_q, completed_key_q;
  logic [TAG_WIDTH-1:0] result_tag_q;
  logic current_fg_q, latest_valid_q, latest_fg_q, result_valid_q, completed_fg_q;

  // key and token compares
  always_comb begin
    stat_o.cur_match = (current_key_q == req_key_i);
    stat_o.res_match = result_valid_q && (result_key_q == req_key_i);
    stat_o.lat_valid = latest_valid_q;
    stat_o.lat_match = (latest_key_q == req_key_i);
    stat_o.tok_zero  = (token_i == '0);
    stat_o.tok_match = (active_token_q == token_i);
  end

  // register updates under controller command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_token_q  <= '0;
      current_key_q   <= '0;
      current_fg_q    <= 1'b0;
      latest_valid_q  <= 1'b0;
      latest_key_q    <= '0;
      latest_fg_q     <= 1'b0;
      result_valid_q  <= 1'b0;
      result_key_q    <= '0;
      result_tag_q    <= '0;
      completed_key_q <= '0;
      completed_fg_q  <= 1'b0;
    end else begin
      if (cmd_i.tok_load) begin
        active_token_q <= token_i;
      end
      if (cmd_i.cur_load_req) begin
        current_key_q <= req_key_i;
        current_fg_q  <= req_foreground_i | (cmd_i.cur_fg_merge & current_fg_q);
      end else if (cmd_i.cur_load_latest) begin
        current_key_q <= latest_key_q;
        current_fg_q  <= latest_fg_q;
      end else if (cmd_i.cur_fg_merge) begin
        current_fg_q <= current_fg_q | req_foreground_i;
      end
      if (cmd_i.lat_load) begin
        latest_valid_q <= 1'b1;
        latest_key_q   <= req_key_i;
        latest_fg_q    <= req_foreground_i;
      end else if (cmd_i.lat_fg_merge) begin
        latest_fg_q <= latest_fg_q | req_foreground_i;
      end else if (cmd_i.lat_clear) begin
        latest_valid_q <= 1'b0;
      end
      if (cmd_i.res_store) begin
        result_valid_q <= 1'b1;
        result_key_q   <= details_key_i;
        result_tag_q   <= details_tag_i;
      end
      // completed request is reported for this item only
      if (cmd_i.item_accept) begin
        completed_key_q <= cmd_i.done_capture ? current_key_q : '0;
        completed_fg_q  <= cmd_i.done_capture & current_fg_q;
      end
    end
  end

  assign current_key_o   = current_key_q;
  assign current_fg_o    = current_fg_q;
  assign completed_key_o = completed_key_q;
  assign completed_fg_o  = completed_fg_q;
  assign result_valid_o  = result_valid_q;
  assign result_key_o    = result_key_q;
  assign result_tag_o    = result_tag_q;

endmodule

// ===== src/keyed_request_slot_coalescer_top.sv =====
// top level of the keyed request slot coalescer
`timescale 1ns / 1ps

// Single-slot request tracker. One item is taken per clock whenever busy is
// low; busy is high in reset and in the first cycle after it. Every item gives one
// result, shown with done_o for exactly one cycle, in the cycle after the item is
// taken; the receiver cannot stall it. The rate is one item per cycle, set by
// the phase register in the controller and the key registers in the datapath,
// which are both updated at the edge that takes the item. Phase, queued
// request and retained result on the outputs show the state after the item.
module keyed_request_slot_coalescer_top #(
  parameter int unsigned KEY_WIDTH = 32,
  parameter int unsigned TAG_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type_i,
  input  logic [KEY_WIDTH-1:0] req_key_i,
  input  logic                 req_foreground_i,
  input  logic [31:0]          token_i,
  input  logic                 details_present_i,
  input  logic [KEY_WIDTH-1:0] details_key_i,
  input  logic [TAG_WIDTH-1:0] details_tag_i,
  output logic                 done_o,
  output logic [3:0]           status_o,
  output logic [KEY_WIDTH-1:0] completed_key_o,
  output logic                 completed_foreground_o,
  output logic [1:0]           slot_phase_o,
  output logic [KEY_WIDTH-1:0] queued_key_o,
  output logic                 queued_foreground_o,
  output logic                 retained_present_o,
  output logic [KEY_WIDTH-1:0] retained_key_o,
  output logic [TAG_WIDTH-1:0] retained_tag_o
);

  krsc_pkg::krsc_cmd_t  cmd;
  krsc_pkg::krsc_stat_t stat;
  logic [KEY_WIDTH-1:0] current_key, result_key;
  logic [TAG_WIDTH-1:0] result_tag;
  logic                 current_fg, result_valid;
  logic                 in_queue;

  // phase controller
  krsc_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .req_type_i        (req_type_i),
    .details_present_i (details_present_i),
    .stat_i            (stat),
    .cmd_o             (cmd),
    .phase_o           (slot_phase_o),
    .status_o          (status_o),
    .done_o            (done_o)
  );

  // request and result registers
  krsc_dpath #(
    .KEY_WIDTH (KEY_WIDTH),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .req_key_i        (req_key_i),
    .req_foreground_i (req_foreground_i),
    .token_i          (token_i),
    .details_key_i    (details_key_i),
    .details_tag_i    (details_tag_i),
    .current_key_o    (current_key),
    .current_fg_o     (current_fg),
    .completed_key_o  (completed_key_o),
    .completed_fg_o   (completed_foreground_o),
    .result_valid_o   (result_valid),
    .result_key_o     (result_key),
    .result_tag_o     (result_tag)
  );

  // report views, zero when not meaningful
  assign in_queue            = (slot_phase_o == krsc_pkg::PH_QUEUED);
  assign queued_key_o        = in_queue ? current_key : '0;
  assign queued_foreground_o = in_queue & current_fg;
  assign retained_present_o  = result_valid;
  assign retained_key_o      = result_valid ? result_key : '0;
  assign retained_tag_o      = result_valid ? result_tag : '0;

endmodule

// ===== src/krsc_checker.sv =====
// port-level checks for the keyed request slot coalescer
`timescale 1ns / 1ps
`include "keyed_request_slot_coalescer_top_defines.svh"

module krsc_checker #(
  parameter int unsigned KEY_WIDTH = 32,
  parameter int unsigned TAG_WIDTH = 32
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 done_o,
  input logic [3:0]           status_o,
  input logic [1:0]           slot_phase_o,
  input logic                 retained_present_o,
  input logic [KEY_WIDTH-1:0] retained_key_o,
  input logic [TAG_WIDTH-1:0] retained_tag_o
);

  // every taken item gets its result in the following cycle
  `KRSC_ASSERT_NEXT(a_item_result, clk_i, rst_ni, start && !busy, done_o, "item without result")

  // an accepted settle leaves the slot idle
  `KRSC_ASSERT_NOW(a_accept_idle, clk_i, rst_ni, done_o && status_o == krsc_pkg::ST_ACCEPTED, slot_phase_o == krsc_pkg::PH_IDLE, "accepted settle not idle")

  // an activation leaves the slot active
  `KRSC_ASSERT_NOW(a_activate_active, clk_i, rst_ni, done_o && status_o == krsc_pkg::ST_ACTIVATED, slot_phase_o == krsc_pkg::PH_ACTIVE, "activation not active")

  // a superseding settle requeues the latest request
  `KRSC_ASSERT_NOW(a_super_queued, clk_i, rst_ni, done_o && status_o == krsc_pkg::ST_SUPERSEDED, slot_phase_o == krsc_pkg::PH_QUEUED, "superseded not queued")

  // no retained result reads as zero
  `KRSC_ASSERT_NOW(a_retained_zero, clk_i, rst_ni, !retained_present_o, retained_key_o == '0 && retained_tag_o == '0, "absent result not zero")

endmodule

bind keyed_request_slot_coalescer_top krsc_checker #(
  .KEY_WIDTH (KEY_WIDTH),
  .TAG_WIDTH (TAG_WIDTH)
) u_krsc_checker (.*);

// ===== tb/keyed_request_slot_coalescer_top_tb.sv =====
// self-checking testbench for the keyed request slot coalescer, with its own slot predictor
`timescale 1ns / 1ps

module keyed_request_slot_coalescer_top_tb;

  localparam int unsigned KW = 32;
  localparam int unsigned TW = 32;
  localparam int unsigned PHASE_ITEMS = 400;

  // one item for the slot, or a pause marker that also sets the sender idle rate
  typedef struct {
    logic          pause;
    int            idle_pct;
    logic [1:0]    kind;
    logic [KW-1:0] key;
    logic          fg;
    logic [31:0]   tok;
    logic          dpres;
    logic [KW-1:0] dkey;
    logic [TW-1:0] dtag;
  } slot_item_t;

  typedef struct {
    logic [3:0]    status;
    logic [KW-1:0] done_key;
    logic          done_fg;
    logic [1:0]    phase;
    logic [KW-1:0] q_key;
    logic          q_fg;
    logic          r_pres;
    logic [KW-1:0] r_key;
    logic [TW-1:0] r_tag;
  } slot_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [1:0]    req_type_i = krsc_pkg::REQ_REQUEST;
  logic [KW-1:0] req_key_i = '0;
  logic          req_foreground_i = 1'b0;
  logic [31:0]   token_i = '0;
  logic          details_present_i = 1'b0;
  logic [KW-1:0] details_key_i = '0;
  logic [TW-1:0] details_tag_i = '0;
  logic          done_o;
  logic [3:0]    status_o;
  logic [KW-1:0] completed_key_o;
  logic          completed_foreground_o;
  logic [1:0]    slot_phase_o;
  logic [KW-1:0] queued_key_o;
  logic          queued_foreground_o;
  logic          retained_present_o;
  logic [KW-1:0] retained_key_o;
  logic [TW-1:0] retained_tag_o;

  slot_item_t   pending_items[$];
  slot_result_t expected_results[$];
  slot_item_t   drv_item;
  int           sender_idle_pct = 0;
  int           issued_cnt = 0;
  int           checked_cnt = 0;
  int           total_items = 0;
  int           mismatches = 0;

  // predicted slot state
  logic [1:0]    sl_phase;
  logic [31:0]   sl_token;
  logic [KW-1:0] cur_key;
  logic          cur_fg;
  logic          lat_valid;
  logic [KW-1:0] lat_key;
  logic          lat_fg;
  logic          ret_valid;
  logic [KW-1:0] ret_key;
  logic [TW-1:0] ret_tag;

  logic [KW-1:0] key_pool[4];

  keyed_request_slot_coalescer_top #(
    .KEY_WIDTH(KW),
    .TAG_WIDTH(TW)
  ) dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start                 (start),
    .busy                  (busy),
    .req_type_i            (req_type_i),
    .req_key_i             (req_key_i),
    .req_foreground_i      (req_foreground_i),
    .token_i               (token_i),
    .details_present_i     (details_present_i),
    .details_key_i         (details_key_i),
    .details_tag_i         (details_tag_i),
    .done_o                (done_o),
    .status_o              (status_o),
    .completed_key_o       (completed_key_o),
    .completed_foreground_o(completed_foreground_o),
    .slot_phase_o          (slot_phase_o),
    .queued_key_o          (queued_key_o),
    .queued_foreground_o   (queued_foreground_o),
    .retained_present_o    (retained_present_o),
    .retained_key_o        (retained_key_o),
    .retained_tag_o        (retained_tag_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // advance the predicted slot by one item and give the expected outcome
  function automatic slot_result_t predict_slot_outcome(slot_item_t it);
    slot_result_t r;
    r.status   = krsc_pkg::ST_IGNORED;
    r.done_key = '0;
    r.done_fg  = 1'b0;
    case (it.kind)
      krsc_pkg::REQ_REQUEST: begin
        if (sl_phase == krsc_pkg::PH_ACTIVE) begin
          if (cur_key == it.key) begin
            // joins the active request, any newer request is dropped
            cur_fg    = cur_fg | it.fg;
            lat_valid = 1'b0;
            r.status  = krsc_pkg::ST_WAITING;
          end else if (ret_valid && ret_key == it.key) begin
            lat_valid = 1'b0;
            r.status  = krsc_pkg::ST_CACHED;
          end else begin
            if (lat_valid && lat_key == it.key) begin
              lat_fg = lat_fg | it.fg;
            end else begin
              lat_valid = 1'b1;
              lat_key   = it.key;
              lat_fg    = it.fg;
            end
            r.status = krsc_pkg::ST_WAITING;
          end
        end else if (ret_valid && ret_key == it.key) begin
          r.status = krsc_pkg::ST_CACHED;
        end else begin
          if (sl_phase == krsc_pkg::PH_QUEUED && cur_key == it.key) begin
            cur_fg = cur_fg | it.fg;
          end else begin
            cur_fg = it.fg;
          end
          sl_phase = krsc_pkg::PH_QUEUED;
          cur_key  = it.key;
          r.status = krsc_pkg::ST_QUEUED;
        end
      end
      krsc_pkg::REQ_ACTIVATE: begin
        if (sl_phase != krsc_pkg::PH_QUEUED || it.tok == '0) begin
          r.status = krsc_pkg::ST_REFUSED;
        end else begin
          sl_phase  = krsc_pkg::PH_ACTIVE;
          sl_token  = it.tok;
          lat_valid = 1'b0;
          r.status  = krsc_pkg::ST_ACTIVATED;
        end
      end
      krsc_pkg::REQ_SETTLE: begin
        if (sl_phase == krsc_pkg::PH_ACTIVE && sl_token == it.tok) begin
          r.done_key = cur_key;
          r.done_fg  = cur_fg;
          if (lat_valid) begin
            // newer request takes the slot, delivered details are dropped
            sl_phase  = krsc_pkg::PH_QUEUED;
            cur_key   = lat_key;
            cur_fg    = lat_fg;
            lat_valid = 1'b0;
            r.status  = krsc_pkg::ST_SUPERSEDED;
          end else begin
            sl_phase = krsc_pkg::PH_IDLE;
            if (it.dpres) begin
              ret_valid = 1'b1;
              ret_key   = it.dkey;
              ret_tag   = it.dtag;
            end
            r.status = krsc_pkg::ST_ACCEPTED;
          end
        end
      end
      default: begin
        ret_valid = 1'b1;
        ret_key   = it.dkey;
        ret_tag   = it.dtag;
        r.status  = krsc_pkg::ST_STORED;
      end
    endcase
    r.phase  = sl_phase;
    r.q_key  = (sl_phase == krsc_pkg::PH_QUEUED) ? cur_key : '0;
    r.q_fg   = (sl_phase == krsc_pkg::PH_QUEUED) ? cur_fg : 1'b0;
    r.r_pres = ret_valid;
    r.r_key  = ret_valid ? ret_key : '0;
    r.r_tag  = ret_valid ? ret_tag : '0;
    return r;
  endfunction

  // driver: one item per handshake, random gaps, waits out pause markers
  always @(posedge clk_i) begin
    logic accepting;
    slot_item_t nxt;
    accepting = start && !busy;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (accepting) begin
        expected_results.push_back(predict_slot_outcome(drv_item));
        issued_cnt <= issued_cnt + 1;
      end
      if (start && !accepting) begin
        // held: keep the item on the ports
      end else if (pending_items.size() > 0 && pending_items[0].pause) begin
        start <= 1'b0;
        if (!accepting && issued_cnt == checked_cnt) begin
          nxt = pending_items.pop_front();
          sender_idle_pct <= nxt.idle_pct;
        end
      end else if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt = pending_items.pop_front();
        drv_item          <= nxt;
        req_type_i        <= nxt.kind;
        req_key_i         <= nxt.key;
        req_foreground_i  <= nxt.fg;
        token_i           <= nxt.tok;
        details_present_i <= nxt.dpres;
        details_key_i     <= nxt.dkey;
        details_tag_i     <= nxt.dtag;
        start             <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    slot_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual status %h", $time, status_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("completed_key", want.done_key, completed_key_o);
        check_field("completed_foreground", 32'(want.done_fg), 32'(completed_foreground_o));
        check_field("slot_phase", 32'(want.phase), 32'(slot_phase_o));
        check_field("queued_key", want.q_key, queued_key_o);
        check_field("queued_foreground", 32'(want.q_fg), 32'(queued_foreground_o));
        check_field("retained_present", 32'(want.r_pres), 32'(retained_present_o));
        check_field("retained_key", want.r_key, retained_key_o);
        check_field("retained_tag", want.r_tag, retained_tag_o);
        checked_cnt <= checked_cnt + 1;
      end
    end
  end

  task automatic add_item(logic [1:0] kind, logic [KW-1:0] key, logic fg, logic [31:0] tok,
                          logic dpres, logic [KW-1:0] dkey, logic [TW-1:0] dtag);
    slot_item_t it;
    it.pause    = 1'b0;
    it.idle_pct = 0;
    it.kind     = kind;
    it.key      = key;
    it.fg       = fg;
    it.tok      = tok;
    it.dpres    = dpres;
    it.dkey     = dkey;
    it.dtag     = dtag;
    pending_items.push_back(it);
    total_items++;
  endtask

  task automatic add_pause(int pct);
    slot_item_t it;
    it = '{pause: 1'b1, idle_pct: pct, kind: krsc_pkg::REQ_REQUEST, key: '0, fg: 1'b0,
           tok: '0, dpres: 1'b0, dkey: '0, dtag: '0};
    pending_items.push_back(it);
  endtask

  function automatic logic [KW-1:0] pick_key();
    if ($urandom_range(9) == 0) return $urandom;
    return key_pool[$urandom_range(3)];
  endfunction

  // well-formed request / activate / settle round with random content
  task automatic add_round();
    logic [31:0] tk;
    int n;
    tk = ($urandom_range(1) == 0) ? 32'($urandom_range(1, 3)) : 32'($urandom);
    if (tk == '0) tk = 32'd1;
    n = $urandom_range(1, 3);
    repeat (n) add_item(krsc_pkg::REQ_REQUEST, pick_key(), 1'($urandom), 32'($urandom),
                        1'($urandom), pick_key(), $urandom);
    if ($urandom_range(6) == 0)
      add_item(krsc_pkg::REQ_STORE, pick_key(), 1'($urandom), 32'($urandom), 1'($urandom),
               pick_key(), $urandom);
    add_item(krsc_pkg::REQ_ACTIVATE, pick_key(), 1'($urandom),
             ($urandom_range(19) == 0) ? '0 : tk, 1'($urandom), pick_key(), $urandom);
    n = $urandom_range(0, 3);
    repeat (n) add_item(krsc_pkg::REQ_REQUEST, pick_key(), 1'($urandom), 32'($urandom),
                        1'($urandom), pick_key(), $urandom);
    add_item(krsc_pkg::REQ_SETTLE, pick_key(), 1'($urandom),
             ($urandom_range(6) == 0) ? tk ^ (32'd1 << $urandom_range(31)) : tk,
             ($urandom_range(3) != 0), pick_key(), $urandom);
  endtask

  // stimulus and end of run
  initial begin
    int idle_plan[4];
    int start_cnt;
    idle_plan = '{0, 60, 0, 15};
    sl_phase  = krsc_pkg::PH_IDLE;
    sl_token  = '0;
    cur_key   = '0;
    cur_fg    = 1'b0;
    lat_valid = 1'b0;
    lat_key   = '0;
    lat_fg    = 1'b0;
    ret_valid = 1'b0;
    ret_key   = '0;
    ret_tag   = '0;

    // directed: refusals, merges, supersede, accept, cached in every phase
    add_item(krsc_pkg::REQ_SETTLE,   '0, 1'b0, 32'd5, 1'b1, 32'd9, 32'd9);
    add_item(krsc_pkg::REQ_ACTIVATE, '0, 1'b0, 32'd1, 1'b0, '0, '0);
    add_item(krsc_pkg::REQ_REQUEST,  '0, 1'b0, '0, 1'b0, '0, '0);
    add_item(krsc_pkg::REQ_REQUEST,  '0, 1'b1, '0, 1'b0, '0, '0);
    add_item(krsc_pkg::REQ_REQUEST,  '1, 1'b0, '1, 1'b1, '1, '1);
    add_item(krsc_pkg::REQ_ACTIVATE, '1, 1'b1, '0, 1'b1, '1, '1);
    add_item(krsc_pkg::REQ_ACTIVATE, '0, 1'b0, '1, 1'b0, '0, '0);
    add_item(krsc_pkg::REQ_ACTIVATE, '0, 1'b0, 32'd3, 1'b0, '0, '0);
    add_item(krsc_pkg::REQ_REQUEST,  '1, 1'b1, '0, 1'b0, '0, '0);
    add_item(krsc_pkg::REQ_REQUEST,  32'h1234, 1'b0, '0, 1'b0, '0, '0);
    add_item(krsc_pkg::REQ_REQUEST,  32'h1234, 1'b1, '0, 1'b0, '0, '0);
    add_item(krsc_pkg::REQ_SETTLE,   '0, 1'b0, 32'd1, 1'b1, 32'd7, 32'd7);
    add_item(krsc_pkg::REQ_SETTLE,   '0, 1'b0, '1, 1'b1, 32'd77, 32'd77);
    add_item(krsc_pkg::REQ_ACTIVATE, '0, 1'b0, 32'd2, 1'b0, '0, '0);
    add_item(krsc_pkg::REQ_SETTLE,   '0, 1'b0, 32'd2, 1'b1, '1, '1);
    add_item(krsc_pkg::REQ_REQUEST,  '1, 1'b1, '0, 1'b0, '0, '0);
    add_item(krsc_pkg::REQ_REQUEST,  32'd5, 1'b0, '0, 1'b0, '0, '0);
    add_item(krsc_pkg::REQ_REQUEST,  '1, 1'b0, '0, 1'b0, '0, '0);
    add_item(krsc_pkg::REQ_ACTIVATE, '0, 1'b0, 32'd9, 1'b0, '0, '0);
    add_item(krsc_pkg::REQ_REQUEST,  32'd6, 1'b0, '0, 1'b0, '0, '0);
    add_item(krsc_pkg::REQ_REQUEST,  '1, 1'b1, '0, 1'b0, '0, '0);
    add_item(krsc_pkg::REQ_REQUEST,  32'd6, 1'b1, '0, 1'b0, '0, '0);
    add_item(krsc_pkg::REQ_REQUEST,  32'd5, 1'b1, '0, 1'b0, '0, '0);
    add_item(krsc_pkg::REQ_SETTLE,   '0, 1'b0, 32'd9, 1'b0, 32'd3, 32'd3);
    add_item(krsc_pkg::REQ_STORE,    '0, 1'b0, '0, 1'b1, '0, '0);

    // random phases, each with its own idle rate and key pool
    foreach (idle_plan[p]) begin
      add_pause(idle_plan[p]);
      foreach (key_pool[k]) key_pool[k] = $urandom;
      if (p == 1) key_pool[0] = '0;
      if (p == 2) key_pool[1] = '1;
      start_cnt = total_items;
      while (total_items - start_cnt < PHASE_ITEMS) begin
        if ($urandom_range(4) == 0) begin
          add_item(2'($urandom), pick_key(), 1'($urandom), $urandom, 1'($urandom), pick_key(),
                   $urandom);
        end else begin
          add_round();
        end
        if ($urandom_range(29) == 0) add_pause(idle_plan[p]);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (checked_cnt != total_items) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (expected_results.size() != 0 || issued_cnt != checked_cnt) begin
      $display("%0t: results outstanding at end, expected 0 actual %0d", $time,
               expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule
